FILE: hdl/arp_cache_with_aging_unit_macros.svh
// Assertion macros for the ARP cache with aging.
// Expects signals named clk and rst in the scope of each use.
`ifndef ARP_CACHE_WITH_AGING_UNIT_MACROS_SVH
`define ARP_CACHE_WITH_AGING_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ARP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("arp cache: assertion failed");
`define ARP_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("arp cache: forbidden condition seen");
`else
`define ARP_ASSERT(lbl, prop)
`define ARP_NEVER(lbl, expr)
`endif
`endif

FILE: hdl/aca_pkg.sv
// Package for the ARP cache with aging: entry layout, mode and status codes.
// No dependencies.
`timescale 1ns / 1ps
package aca_pkg;

  // Transaction modes
  localparam logic [1:0] MODE_LOOKUP  = 2'd0;
  localparam logic [1:0] MODE_REFRESH = 2'd1;
  localparam logic [1:0] MODE_INSERT  = 2'd2;
  localparam logic [1:0] MODE_TICK    = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_MISS    = 3'd0;
  localparam logic [2:0] ST_HIT     = 3'd1;
  localparam logic [2:0] ST_EXPIRED = 3'd2;
  localparam logic [2:0] ST_NEW     = 3'd3;
  localparam logic [2:0] ST_UPDATED = 3'd4;
  localparam logic [2:0] ST_EVICTED = 3'd5;

  // One cache slot as held in memory
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

endpackage

FILE: hdl/arp_cache_with_aging_unit.sv
// ARP cache with entry aging: top level, control sequencer and slot state.
// Depends on aca_pkg, aca_ram and arp_cache_with_aging_unit_macros.svh.
`timescale 1ns / 1ps
`include "arp_cache_with_aging_unit_macros.svh"

// A transaction is taken when start is high and busy is low. A time tick
// (mode 3) does not scan: the result strobe done follows at the next cycle.
// Lookup, lookup with refresh and insert scan every slot through the one read
// port of the entry RAM, one slot per cycle, then pass the drain and act
// states; done pulses as busy falls, and a new transaction may be started in
// that same cycle. Each result (status and found_hw_addr) is valid while done
// is high and holds until the next transaction is taken; the receiver cannot
// hold it off. Slot valid bits clear at reset, so the cache is ready right
// after reset. The user must write timeout_ticks (cfg_we, cfg_wdata) only
// while the block is idle; the block itself does not enforce this.
module arp_cache_with_aging_unit #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  mode,
  input  logic [31:0] ip_addr,
  input  logic [47:0] hw_addr,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  output logic        busy,
  output logic        done,
  output logic [2:0]  status,
  output logic [47:0] found_hw_addr
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam int EW = $bits(aca_pkg::entry_t);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_ACT   = 2'd3;

  logic [1:0]         state;
  logic [30:0]        timeout_ticks;
  logic [31:0]        now_ticks;
  logic [ENTRIES-1:0] entry_valid;

  logic [1:0]         op_mode;
  logic [31:0]        op_ip;
  logic [47:0]        op_hw;

  logic [IW-1:0]      scan_idx;
  logic               cmp_vld;
  logic [IW-1:0]      cmp_idx;

  logic               match_found;
  logic [IW-1:0]      match_idx;
  logic [47:0]        match_mac;
  logic [31:0]        match_stamp;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      oldest_idx;
  logic [31:0]        oldest_age;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  aca_pkg::entry_t    ram_wdata;
  logic [EW-1:0]      ram_rdata;
  aca_pkg::entry_t    rd_entry;

  logic               accept;
  logic [31:0]        cmp_age;
  logic               cmp_valid_bit;
  logic               cmp_hit;
  logic [31:0]        act_age;
  logic               act_expired;
  logic               is_insert;
  logic [IW-1:0]      ins_slot;
  logic [2:0]         act_status;
  logic [47:0]        act_found;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Entry store: one slot per address
  aca_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // Compare the slot read in the previous cycle
  assign rd_entry      = aca_pkg::entry_t'(ram_rdata);
  assign cmp_age       = now_ticks - rd_entry.stamp;
  assign cmp_valid_bit = entry_valid[cmp_idx];
  assign cmp_hit       = cmp_vld && cmp_valid_bit && (rd_entry.ip == op_ip);

  // Decide the outcome once the scan has finished
  assign act_age     = now_ticks - match_stamp;
  assign act_expired = act_age > {1'b0, timeout_ticks};
  assign is_insert   = (op_mode == aca_pkg::MODE_INSERT);
  assign ins_slot    = match_found ? match_idx : (free_found ? free_idx : oldest_idx);

  always_comb begin
    act_status = aca_pkg::ST_MISS;
    act_found  = '0;
    if (is_insert) begin
      if (match_found) begin
        act_status = aca_pkg::ST_UPDATED;
      end else if (free_found) begin
        act_status = aca_pkg::ST_NEW;
      end else begin
        act_status = aca_pkg::ST_EVICTED;
      end
    end else if (match_found) begin
      if (act_expired) begin
        act_status = aca_pkg::ST_EXPIRED;
      end else begin
        act_status = aca_pkg::ST_HIT;
        act_found  = match_mac;
      end
    end
  end

  // Write back: insert fills a slot, refresh restamps a live hit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = match_idx;
    ram_wdata = '{ip: op_ip, mac: match_mac, stamp: now_ticks};
    if (state == S_ACT) begin
      if (is_insert) begin
        ram_we    = 1'b1;
        ram_waddr = ins_slot;
        ram_wdata = '{ip: op_ip, mac: op_hw, stamp: now_ticks};
      end else if (op_mode == aca_pkg::MODE_REFRESH && match_found && !act_expired) begin
        ram_we = 1'b1;
      end
    end
  end

  // Control state, valid bits, tick counter and timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      timeout_ticks <= 31'd15;
      now_ticks     <= '0;
      entry_valid   <= '0;
      scan_idx      <= '0;
      cmp_vld       <= 1'b0;
      done          <= 1'b0;
    end else begin
      done    <= 1'b0;
      cmp_vld <= (state == S_SCAN);
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          scan_idx <= '0;
          if (accept) begin
            if (mode == aca_pkg::MODE_TICK) begin
              now_ticks <= now_ticks + 32'd1;
              done      <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_idx == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_ACT;
        end
        S_ACT: begin
          if (is_insert) begin
            entry_valid[ins_slot] <= 1'b1;
          end else if (match_found && act_expired) begin
            entry_valid[match_idx] <= 1'b0;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the transaction and track match, first free slot and oldest slot
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (accept) begin
      op_mode     <= mode;
      op_ip       <= ip_addr;
      op_hw       <= hw_addr;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      oldest_idx  <= '0;
      oldest_age  <= '0;
    end else if (cmp_vld) begin
      if (cmp_hit && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= cmp_idx;
        match_mac   <= rd_entry.mac;
        match_stamp <= rd_entry.stamp;
      end
      if (!cmp_valid_bit && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
      if (cmp_idx == '0 || cmp_age > oldest_age) begin
        oldest_idx <= cmp_idx;
        oldest_age <= cmp_age;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (state == S_ACT) begin
      status        <= act_status;
      found_hw_addr <= act_found;
    end else if (accept) begin
      status        <= aca_pkg::ST_MISS;
      found_hw_addr <= '0;
    end
  end

  // Checks
  `ARP_ASSERT(a_act_gives_result, (state == S_ACT) |=> (done && !busy))
  `ARP_ASSERT(a_search_goes_busy, (accept && mode != aca_pkg::MODE_TICK) |=> busy)
  `ARP_ASSERT(a_now_only_on_tick, !(accept && mode == aca_pkg::MODE_TICK) |=> $stable(now_ticks))
  `ARP_NEVER(a_addr_only_on_hit, done && status != aca_pkg::ST_HIT && found_hw_addr != '0)

endmodule

FILE: hdl/aca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module aca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [AW-1:0]            raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
